@@ src/assert_macros.svh @@
// Assertion macros shared by the register map block.
// No dependencies; included by the top level only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ src/rrmw_pkg.sv @@
// Package of the robot register map: codes, reset values and shared types.
// No dependencies; used by every module of the block.
`default_nettype none

package rrmw_pkg;

    localparam int NUM_SERVOS = 4;
    localparam int CFG_IDX_W  = 2;

    // Action codes
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;
    localparam logic [1:0] ACT_IDLE  = 2'd3;

    // Register map
    localparam logic [7:0] ADDR_ID         = 8'd0;
    localparam logic [7:0] ADDR_LINK       = 8'd1;
    localparam logic [7:0] ADDR_SERVO0     = 8'd2;
    localparam logic [7:0] ADDR_SERVO_LAST = 8'd5;
    localparam logic [7:0] ADDR_DIR0       = 8'd6;
    localparam logic [7:0] ADDR_DUTY0      = 8'd7;
    localparam logic [7:0] ADDR_DIR1       = 8'd8;
    localparam logic [7:0] ADDR_DUTY1      = 8'd9;
    localparam logic [7:0] ADDR_BEEP       = 8'd10;

    localparam logic [7:0] ID_VALUE  = 8'h2A;
    localparam logic [7:0] DATA_NONE = 8'h00;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFLINE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_SLOW      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_MAX     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_MIDDLE  = 2'd3;

    // Reset values
    localparam logic [7:0] OFFLINE_LIMIT_RST = 8'd30;
    localparam logic [7:0] LED_SLOW_RST      = 8'd10;
    localparam logic [7:0] SERVO_MAX_RST     = 8'd125;
    localparam logic [7:0] SERVO_MIDDLE_RST  = 8'd62;
    localparam logic [7:0] BEEP_TICKS_RST    = 8'd3;

    typedef struct packed {
        logic [7:0] offline_limit;
        logic [7:0] led_slow_period;
        logic [7:0] servo_max;
        logic [7:0] servo_middle;
    } cfg_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       online;
        logic       led;
        logic       buzzer_on;
        logic       motor0_forward;
        logic [7:0] motor0_duty;
        logic       motor1_forward;
        logic [7:0] motor1_duty;
        logic [7:0] servo0_pos;
        logic [7:0] servo1_pos;
        logic [7:0] servo2_pos;
        logic [7:0] servo3_pos;
    } result_t;

endpackage

`default_nettype wire

@@ src/rrmw_cfg.sv @@
// Configuration registers of the robot register map.
// Depends on rrmw_pkg.
`default_nettype none

module rrmw_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [rrmw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                     cfg_data,
    output rrmw_pkg::cfg_t                      cfg
);

    rrmw_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offline_limit   <= rrmw_pkg::OFFLINE_LIMIT_RST;
            cfg_reg.led_slow_period <= rrmw_pkg::LED_SLOW_RST;
            cfg_reg.servo_max       <= rrmw_pkg::SERVO_MAX_RST;
            cfg_reg.servo_middle    <= rrmw_pkg::SERVO_MIDDLE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rrmw_pkg::CFG_OFFLINE_LIMIT: cfg_reg.offline_limit   <= cfg_data;
                rrmw_pkg::CFG_LED_SLOW:      cfg_reg.led_slow_period <= cfg_data;
                rrmw_pkg::CFG_SERVO_MAX:     cfg_reg.servo_max       <= cfg_data;
                rrmw_pkg::CFG_SERVO_MIDDLE:  cfg_reg.servo_middle    <= cfg_data;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ src/rrmw_core.sv @@
// Controller state and its single-pass update for one access or tick.
// Depends on rrmw_pkg; driven from the input register of the top level.
`default_nettype none

module rrmw_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       go,
    input  wire logic [1:0] action,
    input  wire logic [7:0] reg_addr,
    input  wire logic [7:0] wr_data,
    input  wire rrmw_pkg::cfg_t cfg,
    output rrmw_pkg::result_t res
);

    logic       alive_reg, alive_next;
    logic [7:0] link_cnt_reg, link_cnt_next;
    logic [7:0] blink_cnt_reg, blink_cnt_next;
    logic       led_reg, led_next;
    logic [7:0] servo_reg  [rrmw_pkg::NUM_SERVOS];
    logic [7:0] servo_next [rrmw_pkg::NUM_SERVOS];
    logic       dir_reg  [2];
    logic       dir_next [2];
    logic [7:0] duty_reg  [2];
    logic [7:0] duty_next [2];
    logic [7:0] beep_ticks_reg, beep_ticks_next;
    logic       beep_en_reg, beep_en_next;
    logic [7:0] last_reg, last_next;

    logic       is_write;
    logic       servo_range;
    logic [1:0] sidx;
    logic       servo_ok;
    logic [7:0] servo_rd;
    logic [7:0] servo_clamped;
    logic [7:0] link_inc;
    logic       timeout;
    logic       alive_tick;
    logic [7:0] blink_inc;

    assign is_write      = (action == rrmw_pkg::ACT_WRITE);
    assign servo_range   = (reg_addr >= rrmw_pkg::ADDR_SERVO0)
                        && (reg_addr <= rrmw_pkg::ADDR_SERVO_LAST);
    assign sidx          = 2'(reg_addr - rrmw_pkg::ADDR_SERVO0);
    assign servo_ok      = (32'(sidx) < rrmw_pkg::NUM_SERVOS);
    assign servo_clamped = (wr_data > cfg.servo_max) ? cfg.servo_max : wr_data;
    assign link_inc      = link_cnt_reg + 8'd1;
    assign timeout       = (link_inc > cfg.offline_limit);
    assign alive_tick    = alive_reg && !timeout;
    assign blink_inc     = blink_cnt_reg + 8'd1;

    always_comb
    begin
        servo_rd = rrmw_pkg::DATA_NONE;
        for (int i = 0; i < rrmw_pkg::NUM_SERVOS; i++)
        begin
            if (32'(sidx) == i)
                servo_rd = servo_reg[i];
        end
    end

    always_comb
    begin
        alive_next      = alive_reg;
        link_cnt_next   = link_cnt_reg;
        blink_cnt_next  = blink_cnt_reg;
        led_next        = led_reg;
        servo_next      = servo_reg;
        dir_next        = dir_reg;
        duty_next       = duty_reg;
        beep_ticks_next = beep_ticks_reg;
        beep_en_next    = beep_en_reg;
        last_next       = last_reg;

        unique case (action)
            rrmw_pkg::ACT_WRITE, rrmw_pkg::ACT_READ:
            begin
                if (is_write)
                    last_next = wr_data;
                if (servo_range)
                begin
                    if (!servo_ok)
                        last_next = rrmw_pkg::DATA_NONE;
                    else if (!is_write)
                        last_next = servo_rd;
                    else if (alive_reg)
                    begin
                        for (int i = 0; i < rrmw_pkg::NUM_SERVOS; i++)
                        begin
                            if (32'(sidx) == i)
                                servo_next[i] = servo_clamped;
                        end
                    end
                end
                else
                begin
                    unique case (reg_addr)
                        rrmw_pkg::ADDR_ID:
                            if (!is_write)
                                last_next = rrmw_pkg::ID_VALUE;
                        rrmw_pkg::ADDR_LINK:
                            if (is_write)
                            begin
                                alive_next    = 1'b1;
                                link_cnt_next = 8'd0;
                            end
                        rrmw_pkg::ADDR_DIR0:
                            if (!is_write)
                                last_next = {7'd0, dir_reg[0]};
                            else if (alive_reg)
                                dir_next[0] = (wr_data != 8'd0);
                        rrmw_pkg::ADDR_DUTY0:
                            if (!is_write)
                                last_next = duty_reg[0];
                            else if (alive_reg)
                                duty_next[0] = wr_data;
                        rrmw_pkg::ADDR_DIR1:
                            if (!is_write)
                                last_next = {7'd0, dir_reg[1]};
                            else if (alive_reg)
                                dir_next[1] = (wr_data != 8'd0);
                        rrmw_pkg::ADDR_DUTY1:
                            if (!is_write)
                                last_next = duty_reg[1];
                            else if (alive_reg)
                                duty_next[1] = wr_data;
                        rrmw_pkg::ADDR_BEEP:
                            if (is_write)
                            begin
                                beep_ticks_next = wr_data;
                                beep_en_next    = 1'b1;
                            end
                        default:
                            last_next = rrmw_pkg::DATA_NONE;
                    endcase
                end
            end
            rrmw_pkg::ACT_TICK:
            begin
                // watchdog; a limit of 255 lets the counter wrap without timing out
                link_cnt_next = timeout ? 8'd0 : link_inc;
                if (timeout && alive_reg)
                begin
                    alive_next   = 1'b0;
                    duty_next[0] = 8'd0;
                    duty_next[1] = 8'd0;
                    for (int i = 0; i < rrmw_pkg::NUM_SERVOS; i++)
                        servo_next[i] = cfg.servo_middle;
                end
                // LED uses the link state after the watchdog step
                if (alive_tick)
                    led_next = !led_reg;
                else if (blink_inc > cfg.led_slow_period)
                begin
                    blink_cnt_next = 8'd0;
                    led_next       = !led_reg;
                end
                else
                    blink_cnt_next = blink_inc;
                if (beep_ticks_reg != 8'd0)
                    beep_ticks_next = beep_ticks_reg - 8'd1;
                else
                    beep_en_next = 1'b0;
            end
            rrmw_pkg::ACT_IDLE:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg      <= 1'b0;
            link_cnt_reg   <= 8'd0;
            blink_cnt_reg  <= 8'd0;
            led_reg        <= 1'b0;
            for (int i = 0; i < rrmw_pkg::NUM_SERVOS; i++)
                servo_reg[i] <= rrmw_pkg::SERVO_MIDDLE_RST;
            dir_reg[0]     <= 1'b0;
            dir_reg[1]     <= 1'b0;
            duty_reg[0]    <= 8'd0;
            duty_reg[1]    <= 8'd0;
            beep_ticks_reg <= rrmw_pkg::BEEP_TICKS_RST;
            beep_en_reg    <= 1'b1;
            last_reg       <= 8'd0;
        end
        else if (go)
        begin
            alive_reg      <= alive_next;
            link_cnt_reg   <= link_cnt_next;
            blink_cnt_reg  <= blink_cnt_next;
            led_reg        <= led_next;
            servo_reg      <= servo_next;
            dir_reg        <= dir_next;
            duty_reg       <= duty_next;
            beep_ticks_reg <= beep_ticks_next;
            beep_en_reg    <= beep_en_next;
            last_reg       <= last_next;
        end
    end

    // result shows the state as left by this request
    always_comb
    begin
        res.read_data      = last_next;
        res.online         = alive_next;
        res.led            = led_next;
        res.buzzer_on      = beep_en_next;
        res.motor0_forward = dir_next[0];
        res.motor0_duty    = duty_next[0];
        res.motor1_forward = dir_next[1];
        res.motor1_duty    = duty_next[1];
        res.servo0_pos     = (rrmw_pkg::NUM_SERVOS > 0) ? servo_next[0] : 8'd0;
        res.servo1_pos     = 8'd0;
        res.servo2_pos     = 8'd0;
        res.servo3_pos     = 8'd0;
        for (int i = 1; i < rrmw_pkg::NUM_SERVOS; i++)
        begin
            if (i == 1)
                res.servo1_pos = servo_next[i];
            if (i == 2)
                res.servo2_pos = servo_next[i];
            if (i == 3)
                res.servo3_pos = servo_next[i];
        end
    end

endmodule

`default_nettype wire

@@ src/robot_register_map_with_link_watchdog_core.sv @@
// Top level of the robot register map with link watchdog.
// Depends on rrmw_pkg, rrmw_cfg, rrmw_core and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request: a register
//   write, a register read, a 100 ms tick (action) or an idle no-op.
//   Output channel (out_valid / out_stall) returns one result per request:
//   the data byte and the full actuator and status picture after it.
//   An accepted request is registered at the input, processed from there
//   into the result register, and shows as out_valid once it is held there.
//   Throughput is one request per cycle while the output is not stalled;
//   the only loop is the state registers updated in a single pass per request.
//   When the receiver stalls, the result register holds, the input register
//   keeps one more request, and in_stall rises only once both are full.
//   Configuration writes (cfg_we, cfg_index, cfg_data) are registered and are
//   to be made while the block is idle; the block itself does not enforce this.
//   Reset clears both pipeline stages and restores the register reset
//   values: offline, LED off, buzzer on for three ticks, servos mid-way.
`default_nettype none

`include "assert_macros.svh"

module robot_register_map_with_link_watchdog_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [1:0]                     action,
    input  wire logic [7:0]                     reg_addr,
    input  wire logic [7:0]                     wr_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [7:0]                          read_data,
    output logic                                online,
    output logic                                led,
    output logic                                buzzer_on,
    output logic                                motor0_forward,
    output logic [7:0]                          motor0_duty,
    output logic                                motor1_forward,
    output logic [7:0]                          motor1_duty,
    output logic [7:0]                          servo0_pos,
    output logic [7:0]                          servo1_pos,
    output logic [7:0]                          servo2_pos,
    output logic [7:0]                          servo3_pos,
    input  wire logic                           cfg_we,
    input  wire logic [rrmw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                     cfg_data
);

    rrmw_pkg::cfg_t    cfg;
    rrmw_pkg::result_t core_res;
    rrmw_pkg::result_t res_reg;

    logic       s1_valid_reg;
    logic [1:0] s1_action_reg;
    logic [7:0] s1_addr_reg;
    logic [7:0] s1_data_reg;
    logic       out_valid_reg;
    logic       advance;
    logic       go;

    assign advance  = !out_valid_reg || !out_stall;
    assign go       = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;

    rrmw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rrmw_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .action   (s1_action_reg),
        .reg_addr (s1_addr_reg),
        .wr_data  (s1_data_reg),
        .cfg      (cfg),
        .res      (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_action_reg <= action;
            s1_addr_reg   <= reg_addr;
            s1_data_reg   <= wr_data;
        end
        if (go)
            res_reg <= core_res;
    end

    assign out_valid      = out_valid_reg;
    assign read_data      = res_reg.read_data;
    assign online         = res_reg.online;
    assign led            = res_reg.led;
    assign buzzer_on      = res_reg.buzzer_on;
    assign motor0_forward = res_reg.motor0_forward;
    assign motor0_duty    = res_reg.motor0_duty;
    assign motor1_forward = res_reg.motor1_forward;
    assign motor1_duty    = res_reg.motor1_duty;
    assign servo0_pos     = res_reg.servo0_pos;
    assign servo1_pos     = res_reg.servo1_pos;
    assign servo2_pos     = res_reg.servo2_pos;
    assign servo3_pos     = res_reg.servo3_pos;

    // stall only ever holds back a request already waiting in the input stage
    `ASSERT_IMPLIES(a_stall_needs_held, clk, rst_n, in_stall, s1_valid_reg)
    // a request leaving the input stage always turns up as a result
    `ASSERT_NEXT(a_go_gives_result, clk, rst_n, go, out_valid_reg)
    // offline duties are zero: the watchdog clears them and offline writes are dropped
    `ASSERT_IMPLIES(a_offline_motors_off, clk, rst_n, out_valid_reg && !online,
                    motor0_duty == 8'd0 && motor1_duty == 8'd0)

endmodule

`default_nettype wire

@@ tb/sv/robot_register_map_with_link_watchdog_core_tb.sv @@
// Testbench for robot_register_map_with_link_watchdog_core: directed and random register
// requests under several settings, checked result by result against a local register map.
// Depends on rrmw_pkg and the RTL of the block.
`timescale 1ns / 100ps

module robot_register_map_with_link_watchdog_core_tb;

    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct {
        logic [1:0] act;
        logic [7:0] addr;
        logic [7:0] data;
    } req_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [1:0]                     action = rrmw_pkg::ACT_IDLE;
    logic [7:0]                     reg_addr = 8'd0;
    logic [7:0]                     wr_data = 8'd0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [7:0]                     read_data;
    logic                           online;
    logic                           led;
    logic                           buzzer_on;
    logic                           motor0_forward;
    logic [7:0]                     motor0_duty;
    logic                           motor1_forward;
    logic [7:0]                     motor1_duty;
    logic [7:0]                     servo0_pos;
    logic [7:0]                     servo1_pos;
    logic [7:0]                     servo2_pos;
    logic [7:0]                     servo3_pos;
    logic                           cfg_we = 1'b0;
    logic [rrmw_pkg::CFG_IDX_W-1:0] cfg_index = rrmw_pkg::CFG_OFFLINE_LIMIT;
    logic [7:0]                     cfg_data = 8'd0;

    // Local copy of the register map and its settings
    rrmw_pkg::cfg_t cfg;
    logic           link_up;
    logic [7:0]     link_cnt;
    logic [7:0]     blink_cnt;
    logic           led_lvl;
    logic [7:0]     servo_pos [4];
    logic           motor_fwd [2];
    logic [7:0]     motor_duty [2];
    logic [7:0]     beep_cnt;
    logic           beep_on;
    logic [7:0]     last_byte;

    req_t                pending_reqs [$];
    rrmw_pkg::result_t   results_due [$];
    int unsigned gap_pct = 32;
    int unsigned cycles = 0;
    int unsigned mismatches = 0;
    int unsigned requests_taken = 0;
    int unsigned results_checked = 0;
    int unsigned tick_count = 0;
    int unsigned link_losses = 0;
    int unsigned settings_used = 1;

    robot_register_map_with_link_watchdog_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .reg_addr       (reg_addr),
        .wr_data        (wr_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .read_data      (read_data),
        .online         (online),
        .led            (led),
        .buzzer_on      (buzzer_on),
        .motor0_forward (motor0_forward),
        .motor0_duty    (motor0_duty),
        .motor1_forward (motor1_forward),
        .motor1_duty    (motor1_duty),
        .servo0_pos     (servo0_pos),
        .servo1_pos     (servo1_pos),
        .servo2_pos     (servo2_pos),
        .servo3_pos     (servo3_pos),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Applies one request to the local register map and returns the status after it
    function automatic rrmw_pkg::result_t regmap_step(req_t r);
        rrmw_pkg::result_t s;
        logic              wr;
        logic [7:0]        sel;
        int                i;
        if (r.act == rrmw_pkg::ACT_WRITE || r.act == rrmw_pkg::ACT_READ)
        begin
            wr = (r.act == rrmw_pkg::ACT_WRITE);
            if (wr)
                last_byte = r.data;
            if (r.addr == rrmw_pkg::ADDR_ID)
            begin
                if (!wr)
                    last_byte = rrmw_pkg::ID_VALUE;
            end
            else if (r.addr == rrmw_pkg::ADDR_LINK)
            begin
                if (wr)
                begin
                    link_up = 1'b1;
                    link_cnt = 8'd0;
                end
            end
            else if (r.addr >= rrmw_pkg::ADDR_SERVO0 && r.addr <= rrmw_pkg::ADDR_SERVO_LAST)
            begin
                sel = r.addr - rrmw_pkg::ADDR_SERVO0;
                if (sel >= rrmw_pkg::NUM_SERVOS)
                    last_byte = rrmw_pkg::DATA_NONE;
                else if (wr)
                begin
                    if (link_up)
                        servo_pos[sel[1:0]] = (r.data > cfg.servo_max) ? cfg.servo_max
                                                                        : r.data;
                end
                else
                    last_byte = servo_pos[sel[1:0]];
            end
            else if (r.addr >= rrmw_pkg::ADDR_DIR0 && r.addr <= rrmw_pkg::ADDR_DUTY1)
            begin
                // bit 0 picks duty over direction, bit 1 the motor
                sel = r.addr - rrmw_pkg::ADDR_DIR0;
                if (wr)
                begin
                    if (link_up)
                    begin
                        if (sel[0])
                            motor_duty[sel[1]] = r.data;
                        else
                            motor_fwd[sel[1]] = (r.data != 8'd0);
                    end
                end
                else
                    last_byte = sel[0] ? motor_duty[sel[1]] : {7'd0, motor_fwd[sel[1]]};
            end
            else if (r.addr == rrmw_pkg::ADDR_BEEP)
            begin
                if (wr)
                begin
                    beep_cnt = r.data;
                    beep_on = 1'b1;
                end
            end
            else
                last_byte = rrmw_pkg::DATA_NONE;
        end
        else if (r.act == rrmw_pkg::ACT_TICK)
        begin
            tick_count++;
            link_cnt = link_cnt + 8'd1;
            if (link_cnt > cfg.offline_limit)
            begin
                link_cnt = 8'd0;
                if (link_up)
                begin
                    link_up = 1'b0;
                    motor_duty[0] = 8'd0;
                    motor_duty[1] = 8'd0;
                    for (i = 0; i < 4; i++)
                        servo_pos[i] = cfg.servo_middle;
                    link_losses++;
                end
            end
            if (link_up)
                led_lvl = ~led_lvl;
            else
            begin
                blink_cnt = blink_cnt + 8'd1;
                if (blink_cnt > cfg.led_slow_period)
                begin
                    blink_cnt = 8'd0;
                    led_lvl = ~led_lvl;
                end
            end
            if (beep_cnt != 8'd0)
                beep_cnt = beep_cnt - 8'd1;
            else
                beep_on = 1'b0;
        end
        s.read_data      = last_byte;
        s.online         = link_up;
        s.led            = led_lvl;
        s.buzzer_on      = beep_on;
        s.motor0_forward = motor_fwd[0];
        s.motor0_duty    = motor_duty[0];
        s.motor1_forward = motor_fwd[1];
        s.motor1_duty    = motor_duty[1];
        s.servo0_pos     = (rrmw_pkg::NUM_SERVOS > 0) ? servo_pos[0] : 8'd0;
        s.servo1_pos     = (rrmw_pkg::NUM_SERVOS > 1) ? servo_pos[1] : 8'd0;
        s.servo2_pos     = (rrmw_pkg::NUM_SERVOS > 2) ? servo_pos[2] : 8'd0;
        s.servo3_pos     = (rrmw_pkg::NUM_SERVOS > 3) ? servo_pos[3] : 8'd0;
        return s;
    endfunction

    function automatic void push_req(logic [1:0] act, logic [7:0] addr, logic [7:0] data);
        req_t r;
        r.act = act;
        r.addr = addr;
        r.data = data;
        pending_reqs.push_back(r);
    endfunction

    // Mostly well-formed traffic; keepalive rate sets how often the watchdog fires
    function automatic void push_random_req(int unsigned keep_pct);
        int unsigned pick;
        logic [7:0]  data;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 7))
            0: data = 8'h00;
            1: data = 8'hFF;
            2: data = cfg.servo_max;
            3: data = cfg.servo_max + 8'd1;
            default: data = 8'($urandom_range(0, 255));
        endcase
        if (pick < keep_pct)
            push_req(rrmw_pkg::ACT_WRITE, rrmw_pkg::ADDR_LINK, data);
        else if (pick < keep_pct + 35)
            push_req(rrmw_pkg::ACT_TICK, 8'($urandom_range(0, 255)), data);
        else if (pick < keep_pct + 62)
            push_req(rrmw_pkg::ACT_WRITE,
                     8'($urandom_range(rrmw_pkg::ADDR_SERVO0, rrmw_pkg::ADDR_BEEP)), data);
        else if (pick < keep_pct + 82)
            push_req(rrmw_pkg::ACT_READ,
                     8'($urandom_range(rrmw_pkg::ADDR_ID, rrmw_pkg::ADDR_BEEP)), data);
        else if (pick < keep_pct + 90)
            push_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), data);
        else
            push_req($urandom_range(0, 1) ? rrmw_pkg::ACT_WRITE : rrmw_pkg::ACT_READ,
                     8'($urandom_range(rrmw_pkg::ADDR_BEEP + 8'd1, 255)), data);
    endfunction

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || in_valid || results_due.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_settings(rrmw_pkg::cfg_t c);
        logic [rrmw_pkg::CFG_IDX_W-1:0] order [4];
        logic [7:0]                     value [4];
        int                             k;
        order = '{rrmw_pkg::CFG_OFFLINE_LIMIT, rrmw_pkg::CFG_LED_SLOW,
                  rrmw_pkg::CFG_SERVO_MAX, rrmw_pkg::CFG_SERVO_MIDDLE};
        value = '{c.offline_limit, c.led_slow_period, c.servo_max, c.servo_middle};
        for (k = 0; k < 4; k++)
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= order[k];
            cfg_data  <= value[k];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        cfg = c;
        settings_used++;
    endtask

    task automatic run_phase(rrmw_pkg::cfg_t c, int unsigned n, int unsigned keep_pct,
                             int unsigned gap);
        int unsigned k;
        wait_idle();
        write_settings(c);
        gap_pct = gap;
        for (k = 0; k < n; k++)
            push_random_req(keep_pct);
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Request driver
    always @(posedge clk)
    begin
        req_t nxt;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                results_due.push_back(regmap_step('{action, reg_addr, wr_data}));
                requests_taken++;
            end
            if (in_valid && in_stall)
            begin
                // stalled request holds
            end
            else if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= gap_pct)
            begin
                nxt = pending_reqs.pop_front();
                in_valid <= 1'b1;
                action   <= nxt.act;
                reg_addr <= nxt.addr;
                wr_data  <= nxt.data;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        rrmw_pkg::result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: result with none due, read_data %h", $time, read_data);
                    mismatches++;
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("read_data", want.read_data, read_data);
                    check_field("online", 8'(want.online), 8'(online));
                    check_field("led", 8'(want.led), 8'(led));
                    check_field("buzzer_on", 8'(want.buzzer_on), 8'(buzzer_on));
                    check_field("motor0_forward", 8'(want.motor0_forward),
                                8'(motor0_forward));
                    check_field("motor0_duty", want.motor0_duty, motor0_duty);
                    check_field("motor1_forward", 8'(want.motor1_forward),
                                8'(motor1_forward));
                    check_field("motor1_duty", want.motor1_duty, motor1_duty);
                    check_field("servo0_pos", want.servo0_pos, servo0_pos);
                    check_field("servo1_pos", want.servo1_pos, servo1_pos);
                    check_field("servo2_pos", want.servo2_pos, servo2_pos);
                    check_field("servo3_pos", want.servo3_pos, servo3_pos);
                    results_checked++;
                end
            end
            out_stall <= ($urandom_range(0, 99) < gap_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timed out, %0d results still due", $time, results_due.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        rrmw_pkg::cfg_t c;
        int             i;
        cfg = '{rrmw_pkg::OFFLINE_LIMIT_RST, rrmw_pkg::LED_SLOW_RST,
                rrmw_pkg::SERVO_MAX_RST, rrmw_pkg::SERVO_MIDDLE_RST};
        link_up = 1'b0;
        link_cnt = 8'd0;
        blink_cnt = 8'd0;
        led_lvl = 1'b0;
        for (i = 0; i < 4; i++)
            servo_pos[i] = rrmw_pkg::SERVO_MIDDLE_RST;
        motor_fwd = '{1'b0, 1'b0};
        motor_duty = '{8'd0, 8'd0};
        beep_cnt = rrmw_pkg::BEEP_TICKS_RST;
        beep_on = 1'b1;
        last_byte = 8'd0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ID, unmapped addresses, offline writes, clamping, beep countdown
        push_req(rrmw_pkg::ACT_READ,  rrmw_pkg::ADDR_ID,             8'h00);
        push_req(rrmw_pkg::ACT_READ,  8'hFF,                         8'hFF);
        push_req(rrmw_pkg::ACT_WRITE, rrmw_pkg::ADDR_BEEP + 8'd1,    8'hFF);
        push_req(rrmw_pkg::ACT_READ,  rrmw_pkg::ADDR_LINK,           8'h00);
        push_req(rrmw_pkg::ACT_WRITE, rrmw_pkg::ADDR_SERVO0,         8'hFF);
        push_req(rrmw_pkg::ACT_WRITE, rrmw_pkg::ADDR_DUTY0,          8'h80);
        push_req(rrmw_pkg::ACT_READ,  rrmw_pkg::ADDR_SERVO0,         8'h00);
        push_req(rrmw_pkg::ACT_WRITE, rrmw_pkg::ADDR_LINK,           8'h00);
        push_req(rrmw_pkg::ACT_WRITE, rrmw_pkg::ADDR_SERVO0,         8'hFF);
        push_req(rrmw_pkg::ACT_WRITE, rrmw_pkg::ADDR_SERVO0 + 8'd1,
                 rrmw_pkg::SERVO_MAX_RST + 8'd1);
        push_req(rrmw_pkg::ACT_WRITE, rrmw_pkg::ADDR_SERVO_LAST,     8'h00);
        push_req(rrmw_pkg::ACT_WRITE, rrmw_pkg::ADDR_DIR0,           8'h80);
        push_req(rrmw_pkg::ACT_WRITE, rrmw_pkg::ADDR_DUTY0,          8'hFF);
        push_req(rrmw_pkg::ACT_WRITE, rrmw_pkg::ADDR_DIR1,           8'h01);
        push_req(rrmw_pkg::ACT_WRITE, rrmw_pkg::ADDR_DUTY1,          8'h55);
        push_req(rrmw_pkg::ACT_READ,  rrmw_pkg::ADDR_DIR1,           8'h00);
        push_req(rrmw_pkg::ACT_READ,  rrmw_pkg::ADDR_DUTY0,          8'h00);
        push_req(rrmw_pkg::ACT_READ,  rrmw_pkg::ADDR_SERVO_LAST,     8'h00);
        push_req(rrmw_pkg::ACT_IDLE,  8'hAA,                         8'h55);
        push_req(rrmw_pkg::ACT_WRITE, rrmw_pkg::ADDR_BEEP,           8'h00);
        push_req(rrmw_pkg::ACT_TICK,  8'h00,                         8'h00);
        push_req(rrmw_pkg::ACT_WRITE, rrmw_pkg::ADDR_BEEP,           8'h02);
        push_req(rrmw_pkg::ACT_TICK,  8'hFF,                         8'hFF);
        push_req(rrmw_pkg::ACT_WRITE, rrmw_pkg::ADDR_DIR0,           8'h00);
        push_req(rrmw_pkg::ACT_READ,  rrmw_pkg::ADDR_BEEP,           8'h00);
        for (i = 0; i < 150; i++)
            push_random_req(4);

        // Extremes: watchdog on every other tick, LED toggling each offline tick
        c = '{8'd1, 8'd0, 8'd0, 8'd255};
        run_phase(c, 175, 8, 32);
        // Counter wraps without timing out, slow LED never toggles
        c = '{8'd255, 8'd255, 8'd255, 8'd0};
        run_phase(c, 175, 3, 32);
        // No idling on either side
        c = '{8'd8, 8'd3, 8'd200, 8'd100};
        run_phase(c, 175, 5, 0);
        c.offline_limit   = 8'($urandom_range(1, 255));
        c.led_slow_period = 8'($urandom_range(0, 255));
        c.servo_max       = 8'($urandom_range(0, 255));
        c.servo_middle    = 8'($urandom_range(0, 255));
        run_phase(c, 175, $urandom_range(1, 10), 32);
        c = '{rrmw_pkg::OFFLINE_LIMIT_RST, rrmw_pkg::LED_SLOW_RST,
              rrmw_pkg::SERVO_MAX_RST, rrmw_pkg::SERVO_MIDDLE_RST};
        run_phase(c, 175, 2, 32);

        wait_idle();
        repeat (8) @(posedge clk);
        $display("Covered %0d requests under %0d settings: %0d ticks, %0d link losses.",
                 requests_taken, settings_used, tick_count, link_losses);
        $display("%0d results compared field by field, %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0 && results_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
